[rtl/core/sha_pkg.sv]
// Package with SHA-256 constants, state codes and a rotate helper for the round functions.
`timescale 1ns / 1ps

package sha_pkg;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_PAD   = 8'b00000010,
      ST_LEN   = 8'b00000100,
      ST_ROUND = 8'b00001000,
      ST_ADD   = 8'b00010000,
      ST_OUT   = 8'b00100000,
      ST_ZERO  = 8'b01000000,
      ST_LOAD  = 8'b10000000
   } state_type;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
      ror32 = (x >> n) | (x << (32 - n));
   endfunction

endpackage

[rtl/core/sha_ram.sv]
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps

module sha_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[rtl/core/sha256_byte_stream_hasher_top.sv]
// Top level of the SHA-256 byte stream hasher.
//
// The req_ channel carries one message byte (when req_has_byte is set) and an
// end-of-message flag per item. Bytes are written into a 64-byte block buffer.
// After an item that neither fills a block nor ends the message, the next item
// can follow at once. Filling the block starts a compression: ST_LOAD streams
// the buffer RAM into a 16-word window, ST_ROUND runs one round per cycle on
// the shared round unit, and ST_ADD adds into the chaining value.
// On an end-of-message item with f bytes held, the block writes the marker,
// zero and length bytes one per cycle and compresses. When f is 56 or more,
// or the item itself filled the block, a second final block, also written
// one byte per cycle, and one more compression follow. The block then shows
// four 64-bit digest words on the rsp_ channel, most significant first, one
// per accepted item. req_ready stays low during all of this work. A stalled
// receiver simply holds the current digest word; nothing is lost. After the
// fourth word the chaining value returns to the initial values. Reset restores
// the initial state at once; no clearing pass is needed.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_top
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);

   state_type   state_ff, state_in;
   logic [31:0] h_ff [8];
   logic [31:0] h_in [8];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] len_ff, len_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        fin_ff, fin_in;   // compression belongs to finalization
   logic        two_ff, two_in;   // padding needs an extra block
   logic        pad_done_ff, pad_done_in;   // end marker byte is in place
   logic [1:0]  widx_ff, widx_in;

   // Buffer RAM signals.
   logic       wr_en;
   logic [5:0] wr_addr;
   logic [7:0] wr_data;
   logic [5:0] rd_addr;
   logic [7:0] rd_data;

   sha_ram #(.Width(8), .Depth(64)) u_buf (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Shared round unit and schedule step.
   logic [31:0] t1, t2, s0, s1, w_new, k_cur;
   logic [63:0] bits;

   assign k_cur = ROUND_K[cnt_ff[5:0]];
   assign s0    = ror32(w_ff[1], 7) ^ ror32(w_ff[1], 18) ^ (w_ff[1] >> 3);
   assign s1    = ror32(w_ff[14], 17) ^ ror32(w_ff[14], 19) ^ (w_ff[14] >> 10);
   assign w_new = w_ff[0] + s0 + w_ff[9] + s1;
   assign t1 = v_ff[7] + (ror32(v_ff[4], 6) ^ ror32(v_ff[4], 11) ^ ror32(v_ff[4], 25))
             + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + k_cur + w_ff[0];
   assign t2 = (ror32(v_ff[0], 2) ^ ror32(v_ff[0], 13) ^ ror32(v_ff[0], 22))
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   assign bits = {len_ff, 3'b000};

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = {h_ff[{widx_ff, 1'b0}], h_ff[{widx_ff, 1'b1}]};
   assign rsp_word_index  = widx_ff;
   assign rsp_last_word   = (widx_ff == 2'd3);

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      h_in        = h_ff;
      v_in        = v_ff;
      w_in        = w_ff;
      fill_in     = fill_ff;
      len_in      = len_ff;
      cnt_in      = cnt_ff;
      fin_in      = fin_ff;
      two_in      = two_ff;
      pad_done_in = pad_done_ff;
      widx_in     = widx_ff;
      wr_en       = 1'b0;
      wr_addr     = fill_ff;
      wr_data     = req_data_byte;
      rd_addr     = 6'd0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               fin_in = req_end_of_message;
               cnt_in = '0;
               if (req_has_byte) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + 6'd1;
                  len_in  = len_ff + 61'd1;
               end
               if (req_has_byte && fill_ff == 6'd63) begin
                  state_in = ST_LOAD;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // Write the marker byte, then go on to zeros, length or compression.
            wr_en       = 1'b1;
            wr_data     = PAD_BYTE;
            fill_in     = fill_ff + 6'd1;
            pad_done_in = 1'b1;
            two_in      = (fill_ff >= LEN_POS);
            cnt_in      = 7'd0;
            if (fill_ff == 6'd63) begin
               state_in = ST_LOAD;
            end else if (fill_ff == LEN_POS - 6'd1) begin
               state_in = ST_LEN;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            wr_en   = 1'b1;
            wr_data = 8'h00;
            fill_in = fill_ff + 6'd1;
            cnt_in  = 7'd0;
            if (two_ff && fill_ff == 6'd63) begin
               state_in = ST_LOAD;
            end else if (!two_ff && fill_ff == LEN_POS - 6'd1) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            // Length bytes, most significant first.
            wr_en   = 1'b1;
            wr_data = bits[8*(7 - fill_ff[2:0]) +: 8];
            fill_in = fill_ff + 6'd1;
            cnt_in  = 7'd0;
            if (fill_ff == 6'd63) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // Stream the 64 buffer bytes into the word window, one per cycle.
            rd_addr = cnt_ff[5:0];
            cnt_in  = cnt_ff + 7'd1;
            if (cnt_ff == 7'd0) begin
               v_in = h_ff;
            end else begin
               for (int i = 0; i < 15; i++) begin
                  w_in[i] = {w_ff[i][23:0], w_ff[i + 1][31:24]};
               end
               w_in[15] = {w_ff[15][23:0], rd_data};
               if (cnt_ff == 7'd64) begin
                  cnt_in   = 7'd0;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            // One round per cycle while the window slides by one word.
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i + 1];
            end
            w_in[15] = w_new;
            cnt_in   = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               cnt_in   = 7'd0;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            // Chaining add, then decide what the message still needs.
            for (int i = 0; i < 8; i++) begin
               h_in[i] = h_ff[i] + v_ff[i];
            end
            cnt_in = 7'd0;
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (!pad_done_ff) begin
               state_in = ST_PAD;
            end else if (two_ff) begin
               two_in   = 1'b0;
               state_in = ST_ZERO;
            end else begin
               state_in = ST_OUT;
               widx_in  = 2'd0;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               widx_in = widx_ff + 2'd1;
               if (widx_ff == 2'd3) begin
                  state_in    = ST_IDLE;
                  h_in        = INIT_H;
                  fill_in     = 6'd0;
                  len_in      = '0;
                  fin_in      = 1'b0;
                  two_in      = 1'b0;
                  pad_done_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         h_ff        <= INIT_H;
         fill_ff     <= '0;
         len_ff      <= '0;
         cnt_ff      <= '0;
         fin_ff      <= 1'b0;
         two_ff      <= 1'b0;
         widx_ff     <= '0;
         pad_done_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         h_ff        <= h_in;
         fill_ff     <= fill_in;
         len_ff      <= len_in;
         cnt_ff      <= cnt_in;
         fin_ff      <= fin_in;
         two_ff      <= two_in;
         widx_ff     <= widx_in;
         pad_done_ff <= pad_done_in;
      end
   end

   // Working variables and schedule window.
   always_ff @(posedge clock) begin
      v_ff <= v_in;
      w_ff <= w_in;
   end

endmodule
